[hw/rtl/limb_radix_repacker_macros.svh]
// assertion macros for the limb radix repacker
// expect clk and rst in scope at the point of use
`ifndef LIMB_RADIX_REPACKER_MACROS_SVH
`define LIMB_RADIX_REPACKER_MACROS_SVH

// condition implies consequence in the same cycle
`define LRR_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("repacker check failed");

// condition implies consequence in the next cycle
`define LRR_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("repacker check failed");

`endif

[hw/rtl/lrr_pkg.sv]
// shared constants, types and helpers of the limb radix repacker
// no dependencies
`default_nettype none

package lrr_pkg;

  localparam int LIMB_W        = 64;
  localparam int HELD_W        = 7;
  localparam int BUF_W         = 2 * LIMB_W;
  localparam int SEL_W         = 2;
  localparam int COUNT_W       = 5;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;
  localparam int MAX_OUT_LIMBS_DEF = 16;

  // limb width selector codes
  localparam logic [SEL_W-1:0] SEL_W64 = 2'd0;
  localparam logic [SEL_W-1:0] SEL_W52 = 2'd1;
  localparam logic [SEL_W-1:0] SEL_W43 = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_IN_SEL  = 2'd0;
  localparam logic [1:0] REG_OUT_SEL = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;

  localparam logic [SEL_W-1:0]   IN_SEL_RST  = SEL_W64;
  localparam logic [SEL_W-1:0]   OUT_SEL_RST = SEL_W52;
  localparam logic [COUNT_W-1:0] COUNT_RST   = 5'd10;

  typedef struct packed {
    logic [SEL_W-1:0]   in_sel;
    logic [SEL_W-1:0]   out_sel;
    logic [COUNT_W-1:0] count;
  } lrr_cfg_t;

  function automatic logic [HELD_W-1:0] sel_width(input logic [SEL_W-1:0] sel);
    logic [HELD_W-1:0] w;
    unique case (sel)
      SEL_W52: w = 7'd52;
      SEL_W43: w = 7'd43;
      default: w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic [LIMB_W-1:0] low_mask(input logic [HELD_W-1:0] w);
    logic [LIMB_W-1:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (LIMB_W'(1) << w) - LIMB_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lrr_limb_if.sv]
// valid/ready limb channel of the limb radix repacker
// depends on lrr_pkg
`default_nettype none

interface lrr_limb_if import lrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] limb;
  logic              last;

  modport source (output valid, output limb, output last, input ready);
  modport sink (input valid, input limb, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/lrr_cfg_regs.sv]
// configuration registers of the limb radix repacker behind an apb-style port
// depends on lrr_pkg
`default_nettype none

module lrr_cfg_regs import lrr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output lrr_cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_sel  <= IN_SEL_RST;
      cfg.out_sel <= OUT_SEL_RST;
      cfg.count   <= COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IN_SEL:  cfg.in_sel  <= pwdata[SEL_W-1:0];
        REG_OUT_SEL: cfg.out_sel <= pwdata[SEL_W-1:0];
        REG_COUNT:   cfg.count   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_SEL:  prdata = APB_DW'(cfg.in_sel);
      REG_OUT_SEL: prdata = APB_DW'(cfg.out_sel);
      REG_COUNT:   prdata = APB_DW'(cfg.count);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/limb_radix_repacker.sv]
// limb radix repacker top level: pending limb register, 128-bit bit window,
// result register; depends on lrr_pkg, lrr_limb_if, lrr_cfg_regs and the macros header
// Repacks a little-endian multi-precision integer from 64, 52 or 43-bit limbs
// into limbs of one of those widths. Limbs come in least significant first,
// with last on the top limb; out_count result limbs are produced per number
// (truncating, or flushing leftover bits and padding with zero limbs), and
// out_last marks the final one. The shift window emits one result limb per
// cycle while the result register is free, and an input limb stays pending
// until it has released every result it completes; a last limb releases the
// rest up to out_count. Results leave through a register that holds while
// downstream stalls, and the next input limb is taken in the cycle the
// current one finishes. Configure only while idle.
`default_nettype none
`include "limb_radix_repacker_macros.svh"

module limb_radix_repacker import lrr_pkg::*; #(
  parameter int MAX_OUT_LIMBS = MAX_OUT_LIMBS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  lrr_limb_if.sink               in_ch,
  lrr_limb_if.source             out_ch
);

  localparam int CW   = $clog2(MAX_OUT_LIMBS + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  lrr_cfg_t cfg;

  lrr_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // state
  logic [BUF_W-1:0]  bit_buf;
  logic [HELD_W-1:0] bits_held;
  logic [CW-1:0]     limbs_emitted;
  logic              pend_valid;
  logic [LIMB_W-1:0] pend_limb;
  logic              pend_last;
  logic              merged;
  logic              res_valid;
  logic [LIMB_W-1:0] res_limb;
  logic              res_last;

  // window logic
  logic [HELD_W-1:0] win;
  logic [HELD_W-1:0] wout;
  logic [CMPW-1:0]   cnt_raw;
  logic [CW-1:0]     cnt;
  logic              live;
  logic              append_en;
  logic [BUF_W-1:0]  cur_buf;
  logic [HELD_W-1:0] cur_held;
  logic [BUF_W-1:0]  drop_buf;
  logic [HELD_W-1:0] drop_held;
  logic [CW-1:0]     emitted_inc;
  logic              need;
  logic              need2;
  logic              res_free;
  logic              emit;
  logic              pend_done;
  logic              in_fire;

  assign win  = sel_width(cfg.in_sel);
  assign wout = sel_width(cfg.out_sel);

  always_comb begin
    cnt_raw = CMPW'(cfg.count);
    priority if (cnt_raw == '0) begin
      cnt = CW'(1);
    end else if (cnt_raw > CMPW'(MAX_OUT_LIMBS)) begin
      cnt = CW'(MAX_OUT_LIMBS);
    end else begin
      cnt = CW'(cnt_raw);
    end
  end

  assign live      = limbs_emitted < cnt;
  assign append_en = !merged && live;

  always_comb begin
    if (append_en) begin
      cur_buf  = bit_buf | ({{LIMB_W{1'b0}}, pend_limb & low_mask(win)} << bits_held);
      cur_held = bits_held + win;
    end else begin
      cur_buf  = bit_buf;
      cur_held = bits_held;
    end
  end

  assign drop_buf    = cur_buf >> wout;
  assign drop_held   = (cur_held > wout) ? (cur_held - wout) : '0;
  assign emitted_inc = limbs_emitted + CW'(1);

  assign need      = pend_valid && live && ((cur_held >= wout) || pend_last);
  assign need2     = (emitted_inc < cnt) && ((drop_held >= wout) || pend_last);
  assign res_free  = !res_valid || out_ch.ready;
  assign emit      = need && res_free;
  assign pend_done = pend_valid && (need ? (emit && !need2) : 1'b1);

  assign in_ch.ready = !pend_valid || pend_done;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf       <= '0;
      bits_held     <= '0;
      limbs_emitted <= '0;
    end else if (pend_done && pend_last) begin
      bit_buf       <= '0;
      bits_held     <= '0;
      limbs_emitted <= '0;
    end else if (emit) begin
      bit_buf       <= drop_buf;
      bits_held     <= drop_held;
      limbs_emitted <= emitted_inc;
    end else if (pend_done) begin
      bit_buf   <= cur_buf;
      bits_held <= cur_held;
    end
  end

  // pending input limb
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      merged     <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
      merged     <= 1'b0;
    end else if (pend_done) begin
      pend_valid <= 1'b0;
      merged     <= 1'b0;
    end else if (emit) begin
      merged <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_limb <= in_ch.limb;
      pend_last <= in_ch.last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_limb <= cur_buf[LIMB_W-1:0] & low_mask(wout);
      res_last <= emitted_inc == cnt;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.limb  = res_limb;
  assign out_ch.last  = res_last;

  `LRR_ASSERT_NEXT(a_last_clears, pend_done && pend_last, bits_held == '0 && limbs_emitted == '0)
  `LRR_ASSERT_NOW(a_merged_pending, !pend_valid, !merged)
  `LRR_ASSERT_NOW(a_merged_emitted, pend_valid && merged, limbs_emitted != '0)

endmodule

`default_nettype wire
